// ===== rtl/kde_pkg.sv =====
// kde_pkg: shared types and constants for the keypad debounce and event latch
// used by kde_core and keypad_debounce_event_latch; no dependencies
`timescale 1ns / 1ps

package kde_pkg;

   localparam int KEY_IDX_W  = 2;
   localparam int TIME_W     = 32;
   localparam int LEVELS_W   = 4;
   localparam int DEBOUNCE_W = 16;

   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_POLL = 1'b1;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd30;
   // enter key
   localparam logic [KEY_IDX_W-1:0]  LAST_KEY_RESET = 2'd2;

   typedef struct packed {
      logic [LEVELS_W-1:0]  key_levels;
      logic [TIME_W-1:0]    now_ms;
      logic [KEY_IDX_W-1:0] key_index;
      logic                 func;
   } item_type;

   typedef struct packed {
      logic                 pressed;
      logic [KEY_IDX_W-1:0] key_code;
   } result_type;

   // one item handed from the input register to the core
   typedef struct packed {
      logic     fire;
      item_type item;
   } step_type;

endpackage

// ===== rtl/kde_core.sv =====
// kde_core: key state (pending, latched, press times, owed release) and the
// combinational edge/poll decision; depends on kde_pkg
`timescale 1ns / 1ps

module kde_core #(
   parameter int NUM_KEYS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [kde_pkg::DEBOUNCE_W-1:0]     csr_wr_data,
   input  kde_pkg::step_type                  step,
   output kde_pkg::result_type                result
);

   localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   logic [kde_pkg::DEBOUNCE_W-1:0] debounce_ff;
   logic [NUM_KEYS-1:0]            pending_ff, pending_in;
   logic [NUM_KEYS-1:0]            latched_ff, latched_in;
   logic [kde_pkg::TIME_W-1:0]     last_time_ff [NUM_KEYS];
   logic [kde_pkg::KEY_IDX_W-1:0]  last_key_ff, last_key_in;
   logic                           owed_ff, owed_in;

   logic [NUM_KEYS-1:0]            pins;
   logic [NUM_KEYS-1:0]            key_bit;
   logic                           key_ok;
   logic [IDX_W-1:0]               key_addr;
   logic [kde_pkg::TIME_W-1:0]     elapsed;
   logic                           edge_take;
   logic                           any_pending;
   logic [kde_pkg::KEY_IDX_W-1:0]  pick;
   logic [NUM_KEYS-1:0]            pick_bit;

   // keys without a level bit read low
   assign pins     = NUM_KEYS'(step.item.key_levels);
   assign key_ok   = (32'(step.item.key_index) < NUM_KEYS);
   assign key_addr = IDX_W'(step.item.key_index);
   assign key_bit  = NUM_KEYS'(1) << step.item.key_index;
   assign elapsed  = step.item.now_ms - last_time_ff[key_addr];
   assign edge_take = key_ok && ((latched_ff & key_bit) == '0)
                      && (elapsed >= kde_pkg::TIME_W'(debounce_ff))
                      && ((pins & key_bit) == '0);

   // lowest pending key
   always_comb begin
      pick     = '0;
      pick_bit = '0;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            pick     = kde_pkg::KEY_IDX_W'(i);
            pick_bit = NUM_KEYS'(1) << i;
         end
      end
   end
   assign any_pending = |pending_ff;

   always_comb begin
      pending_in  = pending_ff;
      latched_in  = latched_ff;
      last_key_in = last_key_ff;
      owed_in     = owed_ff;
      result.key_code = last_key_ff;
      result.pressed  = 1'b0;
      if (step.item.func == kde_pkg::FUNC_EDGE) begin
         if (edge_take) begin
            pending_in = pending_ff | key_bit;
            latched_in = latched_ff | key_bit;
         end
      end else begin
         latched_in = latched_ff & ~pins;
         priority if (owed_ff) begin
            owed_in = 1'b0;
         end else if (any_pending) begin
            pending_in      = pending_ff & ~pick_bit;
            last_key_in     = pick;
            owed_in         = 1'b1;
            result.key_code = pick;
            result.pressed  = 1'b1;
         end else begin
            owed_in = owed_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= kde_pkg::DEBOUNCE_RESET;
         pending_ff  <= '0;
         latched_ff  <= '0;
         last_key_ff <= kde_pkg::LAST_KEY_RESET;
         owed_ff     <= 1'b0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            last_time_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            debounce_ff <= csr_wr_data;
         end
         if (step.fire) begin
            pending_ff  <= pending_in;
            latched_ff  <= latched_in;
            last_key_ff <= last_key_in;
            owed_ff     <= owed_in;
            if ((step.item.func == kde_pkg::FUNC_EDGE) && edge_take) begin
               last_time_ff[key_addr] <= step.item.now_ms;
            end
         end
      end
   end

endmodule

// ===== rtl/keypad_debounce_event_latch.sv =====
// a poll transfer gives its result on rsp through the input register and then the result register;
// an edge transfer gives no result and updates the key state as it leaves the input register
// throughput: one item per cycle, set by the single input register and result register;
// a poll stalls only while a result waits on rsp_tready
// reset: synchronous, active high; clears all key state, debounce_ms back to 30
// top level: input register, kde_core and result register; depends on kde_pkg, kde_core
`timescale 1ns / 1ps

module keypad_debounce_event_latch #(
   parameter int NUM_KEYS = 4
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: debounce_ms
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // key_index[1:0], now_ms[33:2], key_levels[37:34], zero
   input  logic        req_tuser,  // func
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // key_code[1:0], zero
   output logic        rsp_tuser   // pressed
);

   logic                in_valid_ff, in_valid_in;
   kde_pkg::item_type   in_item_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   kde_pkg::result_type rsp_ff;
   kde_pkg::result_type core_result;
   kde_pkg::step_type   step;
   logic                stall;
   logic                req_fire;
   logic                is_poll;

   assign is_poll   = (in_item_ff.func == kde_pkg::FUNC_POLL);
   // a poll cannot move on while the previous result is still held
   assign stall     = in_valid_ff && is_poll && rsp_valid_ff && !rsp_tready;
   assign req_tready = !in_valid_ff || !stall;
   assign req_fire  = req_tvalid && req_tready;

   assign step.fire = in_valid_ff && !stall;
   assign step.item = in_item_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step.fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step.fire && is_poll) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   kde_core #(
      .NUM_KEYS (NUM_KEYS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step),
      .result      (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.func       <= req_tuser;
         in_item_ff.key_index  <= req_tdata[1:0];
         in_item_ff.now_ms     <= req_tdata[33:2];
         in_item_ff.key_levels <= req_tdata[37:34];
      end
      if (step.fire && is_poll) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.key_code};
   assign rsp_tuser  = rsp_ff.pressed;

endmodule
